// ----- rtl/core/evzr_pkg.sv -----
package evzr_pkg;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_YAW   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PITCH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROLL  = 2'd2;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef logic signed [17:0] t_coef;
    typedef logic signed [15:0] t_comp;
    typedef logic signed [16:0] t_ocomp;
    typedef t_coef  t_mat [9];
    typedef t_comp  t_vec [3];
    typedef t_ocomp t_res [3];

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // round a q16 value to integer, ties away from zero
    function automatic logic signed [23:0] rnd_q16(input logic signed [39:0] v);
        logic signed [39:0] t;
        t = v + 40'sd32767 + {39'd0, ~v[39]};
        return t[39:16];
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] div_term(input logic [63:0] x, input int k);
        logic [63:0] q;
        unique case (k)
            1:       q = x / 64'd6;
            2:       q = x / 64'd20;
            3:       q = x / 64'd42;
            4:       q = x / 64'd72;
            5:       q = x / 64'd110;
            6:       q = x / 64'd156;
            7:       q = x / 64'd210;
            8:       q = x / 64'd272;
            9:       q = x / 64'd342;
            10:      q = x / 64'd420;
            11:      q = x / 64'd506;
            12:      q = x / 64'd600;
            13:      q = x / 64'd702;
            default: q = x;
        endcase
        return q;
    endfunction

    // quarter-wave sine in q16, taylor series in q62, elaboration only
    function automatic logic [16:0] quarter_sine(input int r, input int qb);
        logic [63:0] frac;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rs;
        frac = 64'(r) << (62 - qb);
        t    = mul_q62(HALF_PI_Q62, frac);
        t2   = mul_q62(t, t);
        term = t;
        sum  = t;
        for (int k = 1; k <= 13; k++) begin
            term = div_term(mul_q62(term, t2), k);
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rs = (sum + (64'd1 << 45)) >> 46;
        return rs[16:0];
    endfunction

endpackage

// ----- rtl/core/euler_zyx_vector_rotator.sv -----
// Rotates signed 16-bit 3-vectors by Rz(yaw)*Ry(pitch)*Rx(roll) held as a
// Q2.16 matrix. Angles are binary angles (2^ANGLE_BITS per turn) written through
// the config port at index 0 yaw, 1 pitch, 2 roll; other indexes are ignored.
// Each write starts a rebuild of the matrix by a sine table and one shared
// multiply-accumulate unit, during which s_axis_tready is low. Otherwise one
// word is taken every cycle while the output is not stalled and passes through
// a three-stage multiply / sum / round pipeline; the whole pipeline holds while
// a result waits with m_axis_tready low. Outputs are rounded half away from
// zero and saturated to 17 bits.
module euler_zyx_vector_rotator #(
    parameter int ANGLE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vec_x, vec_y, vec_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // out_x, out_y, out_z, zero pad
);
    import evzr_pkg::*;

    t_cfg_wr l_cfg;
    t_mat    l_mat;
    t_vec    l_vec;
    t_res    l_res;
    logic    l_busy;
    logic    l_adv;
    logic    l_out_v;

    assign l_cfg.we   = i_cfg_we;
    assign l_cfg.addr = i_cfg_addr;
    assign l_cfg.data = i_cfg_data;

    assign l_vec[0] = s_axis_tdata[15:0];
    assign l_vec[1] = s_axis_tdata[31:16];
    assign l_vec[2] = s_axis_tdata[47:32];

    assign l_adv         = !l_out_v || m_axis_tready;
    assign s_axis_tready = l_adv && !l_busy;

    evzr_matrix_gen #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_mgen (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (l_cfg),
        .o_mat  (l_mat),
        .o_busy (l_busy)
    );

    evzr_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (l_adv),
        .i_vld  (s_axis_tvalid && s_axis_tready),
        .i_vec  (l_vec),
        .i_mat  (l_mat),
        .o_vld  (l_out_v),
        .o_res  (l_res)
    );

    assign m_axis_tvalid = l_out_v;
    assign m_axis_tdata  = {5'd0, l_res[2], l_res[1], l_res[0]};

endmodule

// ----- rtl/core/evzr_matrix_gen.sv -----
module evzr_matrix_gen #(
    parameter int ANGLE_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  evzr_pkg::t_cfg_wr i_cfg,
    output evzr_pkg::t_mat    o_mat,
    output logic              o_busy
);
    import evzr_pkg::*;

    localparam int QB = ANGLE_BITS - 2;
    localparam int QN = 1 << QB;
    localparam logic [4:0] LAST_STEP = 5'd26;

    typedef logic [16:0] t_tab [QN+1];
    typedef enum logic [3:0] {
        DST_ZY0, DST_ZY2, DST_ZY3, DST_ZY5,
        DST_M1, DST_M2, DST_M4, DST_M5, DST_M7, DST_M8
    } t_dst;

    function automatic t_tab build_tab();
        t_tab tb;
        for (int i = 0; i <= QN; i++) begin
            tb[i] = quarter_sine(i, QB);
        end
        return tb;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // trig slots: sin/cos of yaw, pitch, roll
    localparam int T_SZ = 0;
    localparam int T_CZ = 1;
    localparam int T_SY = 2;
    localparam int T_CY = 3;
    localparam int T_SX = 4;
    localparam int T_CX = 5;

    logic [ANGLE_BITS-1:0] r_yaw, r_pitch, r_roll;
    logic                  r_busy;
    logic [4:0]            r_step;
    t_mat                  r_mat;
    logic [ANGLE_BITS+CFG_DATA_W-1:0] l_ext;
    logic [ANGLE_BITS-1:0] l_new;
    logic                  l_cfg_hit;

    // table lookup
    logic [ANGLE_BITS-1:0] l_ang, l_a;
    logic [1:0]            l_quad;
    logic [QB:0]           l_idx;
    logic                  r_lk_v, r_lk_neg;
    logic [2:0]            r_lk_dst;
    logic [16:0]           r_rom_q;
    t_coef                 r_trig [6];

    // multiply-accumulate
    logic                  l_mv, l_mf, l_ml;
    t_dst                  l_mdst;
    t_coef                 l_ma, l_mb;
    logic                  r_pv, r_pf, r_pl, r_av;
    t_dst                  r_pdst, r_adst;
    logic signed [35:0]    r_prod;
    logic signed [36:0]    r_acc;
    t_coef                 r_zy0, r_zy2, r_zy3, r_zy5;
    logic signed [23:0]    l_rnd;
    t_coef                 l_wval;

    assign l_ext     = {{ANGLE_BITS{1'b0}}, i_cfg.data};
    assign l_new     = l_ext[ANGLE_BITS-1:0];
    assign l_cfg_hit = i_cfg.we &&
                       (i_cfg.addr == REG_YAW || i_cfg.addr == REG_PITCH ||
                        i_cfg.addr == REG_ROLL);

    always_comb begin
        unique case (r_step[2:1])
            2'd0:    l_ang = r_yaw;
            2'd1:    l_ang = r_pitch;
            default: l_ang = r_roll;
        endcase
        // cosine is the sine a quarter turn ahead
        l_a    = l_ang + (r_step[0] ? ANGLE_BITS'(QN) : '0);
        l_quad = l_a[ANGLE_BITS-1 -: 2];
        l_idx  = l_quad[0] ? ((QB+1)'(QN) - {1'b0, l_a[QB-1:0]}) : {1'b0, l_a[QB-1:0]};
    end

    always_comb begin
        l_mv   = 1'b1;
        l_mf   = 1'b1;
        l_ml   = 1'b1;
        l_mdst = DST_ZY0;
        l_ma   = '0;
        l_mb   = '0;
        case (r_step)
            5'd8:  begin l_ma = r_trig[T_CZ]; l_mb = r_trig[T_CY]; l_mdst = DST_ZY0; end
            5'd9:  begin l_ma = r_trig[T_CZ]; l_mb = r_trig[T_SY]; l_mdst = DST_ZY2; end
            5'd10: begin l_ma = r_trig[T_SZ]; l_mb = r_trig[T_CY]; l_mdst = DST_ZY3; end
            5'd11: begin l_ma = r_trig[T_SZ]; l_mb = r_trig[T_SY]; l_mdst = DST_ZY5; end
            5'd14: begin l_ma = -r_trig[T_SZ]; l_mb = r_trig[T_CX]; l_ml = 1'b0; end
            5'd15: begin l_ma = r_zy2; l_mb = r_trig[T_SX]; l_mf = 1'b0; l_mdst = DST_M1; end
            5'd16: begin l_ma = r_zy2; l_mb = r_trig[T_CX]; l_ml = 1'b0; end
            5'd17: begin
                l_ma = -r_trig[T_SZ]; l_mb = -r_trig[T_SX]; l_mf = 1'b0; l_mdst = DST_M2;
            end
            5'd18: begin l_ma = r_trig[T_CZ]; l_mb = r_trig[T_CX]; l_ml = 1'b0; end
            5'd19: begin l_ma = r_zy5; l_mb = r_trig[T_SX]; l_mf = 1'b0; l_mdst = DST_M4; end
            5'd20: begin l_ma = r_zy5; l_mb = r_trig[T_CX]; l_ml = 1'b0; end
            5'd21: begin
                l_ma = r_trig[T_CZ]; l_mb = -r_trig[T_SX]; l_mf = 1'b0; l_mdst = DST_M5;
            end
            5'd22: begin l_ma = r_trig[T_CY]; l_mb = r_trig[T_SX]; l_mdst = DST_M7; end
            5'd23: begin l_ma = r_trig[T_CY]; l_mb = r_trig[T_CX]; l_mdst = DST_M8; end
            default: l_mv = 1'b0;
        endcase
    end

    always_comb begin
        l_rnd = rnd_q16(40'(r_acc));
        if (l_rnd > 24'sd131071) begin
            l_wval = 18'sd131071;
        end else if (l_rnd < -24'sd131072) begin
            l_wval = -18'sd131072;
        end else begin
            l_wval = l_rnd[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q  <= SINE_TAB[l_idx];
        r_lk_neg <= l_quad[1];
        r_lk_dst <= r_step[2:0];
        if (r_lk_v) begin
            r_trig[r_lk_dst] <= r_lk_neg ? -t_coef'({1'b0, r_rom_q}) : t_coef'({1'b0, r_rom_q});
        end
        r_prod <= l_ma * l_mb;
        r_pf   <= l_mf;
        r_pl   <= l_ml;
        r_pdst <= l_mdst;
        r_adst <= r_pdst;
        if (r_pv) begin
            r_acc <= r_pf ? 37'(r_prod) : r_acc + 37'(r_prod);
        end
        if (r_av) begin
            case (r_adst)
                DST_ZY0: r_zy0 <= l_wval;
                DST_ZY2: r_zy2 <= l_wval;
                DST_ZY3: r_zy3 <= l_wval;
                DST_ZY5: r_zy5 <= l_wval;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_lk_v  <= 1'b0;
            r_pv    <= 1'b0;
            r_av    <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= (i % 4 == 0) ? 18'sd65536 : 18'sd0;
            end
        end else begin
            r_lk_v <= r_busy && (r_step <= 5'd5);
            r_pv   <= r_busy && l_mv;
            r_av   <= r_pv && r_pl;
            if (l_cfg_hit) begin
                unique case (i_cfg.addr)
                    REG_YAW:   r_yaw   <= l_new;
                    REG_PITCH: r_pitch <= l_new;
                    default:   r_roll  <= l_new;
                endcase
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == LAST_STEP) begin
                    r_busy   <= 1'b0;
                    r_mat[0] <= r_zy0;
                    r_mat[3] <= r_zy3;
                    r_mat[6] <= -r_trig[T_SY];
                end
            end
            if (r_av) begin
                case (r_adst)
                    DST_M1:  r_mat[1] <= l_wval;
                    DST_M2:  r_mat[2] <= l_wval;
                    DST_M4:  r_mat[4] <= l_wval;
                    DST_M5:  r_mat[5] <= l_wval;
                    DST_M7:  r_mat[7] <= l_wval;
                    DST_M8:  r_mat[8] <= l_wval;
                    default: ;
                endcase
            end
        end
    end

    assign o_mat  = r_mat;
    assign o_busy = r_busy;

endmodule

// ----- rtl/core/evzr_datapath.sv -----
module evzr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  evzr_pkg::t_vec i_vec,
    input  evzr_pkg::t_mat i_mat,
    output logic           o_vld,
    output evzr_pkg::t_res o_res
);
    import evzr_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic signed [33:0] r_p1 [9];
    logic signed [35:0] r_s2 [3];
    t_res               r_o3;
    logic signed [23:0] l_rnd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            l_rnd[i] = rnd_q16(40'(r_s2[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p1[i*3+k] <= i_mat[i*3+k] * i_vec[k];
                end
                r_s2[i] <= 36'(r_p1[i*3]) + 36'(r_p1[i*3+1]) + 36'(r_p1[i*3+2]);
                if (l_rnd[i] > 24'sd65535) begin
                    r_o3[i] <= 17'sd65535;
                end else if (l_rnd[i] < -24'sd65536) begin
                    r_o3[i] <= -17'sd65536;
                end else begin
                    r_o3[i] <= l_rnd[i][16:0];
                end
            end
        end
    end

    assign o_vld = r_v3;
    assign o_res = r_o3;

endmodule

// ----- rtl/core/evzr_checker.sv -----
module evzr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_addr,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    import evzr_pkg::*;

    // a rebuild must close the input
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_addr == REG_YAW || i_cfg_addr == REG_PITCH ||
                     i_cfg_addr == REG_ROLL) |=> !s_axis_tready)
        else $error("input open during matrix rebuild");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind euler_zyx_vector_rotator evzr_checker u_chk (.*);
